/* rtl/core/tx_queue_retry_scheduler_macros.svh */
// Assertion macros for the transmit queue retry scheduler checker.
// Plain text macros, no dependencies.
`ifndef TX_QUEUE_RETRY_SCHEDULER_MACROS_SVH
`define TX_QUEUE_RETRY_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TQRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tqrs check failed");

// next-cycle implication, disabled while reset is asserted
`define TQRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tqrs check failed");

`endif

/* rtl/core/tqrs_pkg.sv */
// Types and constants shared by the transmit queue retry scheduler.
// No dependencies.
package tqrs_pkg;

    localparam int COPY_BYTES   = 256;
    localparam int COPY_OFF_W   = 8;
    localparam int COPY_USED_W  = 9;
    localparam int HANDLE_W     = 16;
    localparam int LENGTH_W     = 8;
    localparam int LIMIT_W      = 8;
    localparam int OP_W         = 2;

    localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET = 8'd6;
    localparam logic [LIMIT_W-1:0] RETRY_COUNT_MAX   = 8'd255;

    localparam logic [OP_W-1:0] OP_ENQ_REF  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQ_COPY = 2'd1;
    localparam logic [OP_W-1:0] OP_CONFIRM  = 2'd2;
    localparam logic [OP_W-1:0] OP_TIMER    = 2'd3;

    localparam logic SRC_REF  = 1'b0;
    localparam logic SRC_COPY = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [HANDLE_W-1:0] message_handle;
        logic [LENGTH_W-1:0] message_length;
        logic                confirm_ok;
    } item_t;

    typedef struct packed {
        logic                  accepted;
        logic [COPY_OFF_W-1:0] write_offset;
        logic                  send_valid;
        logic                  send_source;
        logic [HANDLE_W-1:0]   send_handle;
        logic [LENGTH_W-1:0]   send_length;
        logic                  start_retry_timer;
        logic                  dropped;
    } res_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

/* rtl/core/tx_queue_retry_scheduler.sv */
// Transmit queue retry scheduler, top level: input stage, reference and
// copy-length queues, send scheduler and result register.
// Depends on tqrs_pkg, tqrs_fifo and tqrs_sched.
//
// Usage: each s_ transaction carries one event (enqueue reference, enqueue
// copy, send confirmation, retry timer expiry) and yields exactly one m_
// transaction describing acceptance, copy ring offset, the send request if
// any, a retry timer request and a drop flag. Only one send is outstanding;
// the reference queue is served before the copy ring.
// The cfg_ channel writes retry_limit; cfg_ready is always high. Write it
// only while no event is in flight.
// An event passes the input register, then the result register, before m_valid
// rises. Throughput: one event per cycle while the receiver does not stall, set
// by the single pass through the scheduler logic between those registers.
// Reset (aresetn low, synchronous) empties both queues, clears the copy
// ring accounting and the current send, and sets retry_limit to 6.
// When the receiver stalls, the result is held and the input register
// still takes one more event; after that s_ready drops until m_ready.
module tx_queue_retry_scheduler
    import tqrs_pkg::*;
#(
    parameter int REF_DEPTH      = 64,
    parameter int COPY_MSG_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [HANDLE_W-1:0]   s_message_handle,
    input  logic [LENGTH_W-1:0]   s_message_length,
    input  logic                  s_confirm_ok,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_accepted,
    output logic [COPY_OFF_W-1:0] m_write_offset,
    output logic                  m_send_valid,
    output logic                  m_send_source,
    output logic [HANDLE_W-1:0]   m_send_handle,
    output logic [LENGTH_W-1:0]   m_send_length,
    output logic                  m_start_retry_timer,
    output logic                  m_dropped,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LIMIT_W-1:0]    cfg_retry_limit
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       m_valid_reg;
    res_t       m_res_reg;
    logic       advance;
    res_t       res;
    fifo_ctrl_t ref_ctrl;
    fifo_ctrl_t copy_ctrl;
    fifo_stat_t ref_stat;
    fifo_stat_t copy_stat;
    logic [HANDLE_W+LENGTH_W-1:0] ref_head;
    logic [LENGTH_W-1:0]          copy_head;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.operation      <= s_operation;
            in_item_reg.message_handle <= s_message_handle;
            in_item_reg.message_length <= s_message_length;
            in_item_reg.confirm_ok     <= s_confirm_ok;
        end
    end

    tqrs_fifo #(
        .DEPTH (REF_DEPTH),
        .WIDTH (HANDLE_W + LENGTH_W)
    ) u_ref_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ref_ctrl),
        .wdata     ({in_item_reg.message_handle, in_item_reg.message_length}),
        .head_data (ref_head),
        .stat      (ref_stat)
    );

    tqrs_fifo #(
        .DEPTH (COPY_MSG_DEPTH),
        .WIDTH (LENGTH_W)
    ) u_copy_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (copy_ctrl),
        .wdata     (in_item_reg.message_length),
        .head_data (copy_head),
        .stat      (copy_stat)
    );

    tqrs_sched u_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (in_item_reg),
        .ref_head  (ref_head),
        .ref_stat  (ref_stat),
        .copy_head (copy_head),
        .copy_stat (copy_stat),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_data  (cfg_retry_limit),
        .ref_ctrl  (ref_ctrl),
        .copy_ctrl (copy_ctrl),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_res_reg <= res;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_accepted          = m_res_reg.accepted;
    assign m_write_offset      = m_res_reg.write_offset;
    assign m_send_valid        = m_res_reg.send_valid;
    assign m_send_source       = m_res_reg.send_source;
    assign m_send_handle       = m_res_reg.send_handle;
    assign m_send_length       = m_res_reg.send_length;
    assign m_start_retry_timer = m_res_reg.start_retry_timer;
    assign m_dropped           = m_res_reg.dropped;

endmodule

/* rtl/core/tqrs_fifo.sv */
// Descriptor queue: memory with one write and one registered read port,
// head entry prefetched every cycle. Depends on tqrs_pkg.
module tqrs_fifo
    import tqrs_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  fifo_ctrl_t       ctrl,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] head_data,
    output fifo_stat_t       stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [WIDTH-1:0] rd_data_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop && !ctrl.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (ctrl.push && (wr_ptr_reg == rd_ptr_next)) begin
            rd_data_reg <= wdata;
        end else begin
            rd_data_reg <= mem[rd_ptr_next];
        end
    end

    assign head_data  = rd_data_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_FULL);

endmodule

/* rtl/core/tqrs_sched.sv */
// Send scheduler: current descriptor, retry counting, copy ring accounting
// and the result of each transaction. Depends on tqrs_pkg.
module tqrs_sched
    import tqrs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  item_t                      item,
    input  logic [HANDLE_W+LENGTH_W-1:0] ref_head,
    input  fifo_stat_t                 ref_stat,
    input  logic [LENGTH_W-1:0]        copy_head,
    input  fifo_stat_t                 copy_stat,
    input  logic                       cfg_fire,
    input  logic [LIMIT_W-1:0]         cfg_data,
    output fifo_ctrl_t                 ref_ctrl,
    output fifo_ctrl_t                 copy_ctrl,
    output res_t                       res
);

    logic                   waiting_reg, waiting_next;
    logic [LIMIT_W-1:0]     retry_reg, retry_next;
    logic                   src_reg, src_next;
    logic [HANDLE_W-1:0]    handle_reg, handle_next;
    logic [LENGTH_W-1:0]    length_reg, length_next;
    logic [COPY_OFF_W-1:0]  copy_start_reg, copy_start_next;
    logic [COPY_OFF_W-1:0]  copy_end_reg, copy_end_next;
    logic [COPY_USED_W-1:0] copy_used_reg, copy_used_next;
    logic [LIMIT_W-1:0]     limit_reg;

    logic                   len_ok;
    logic                   copy_fits;
    logic                   finish;
    logic                   try_send;
    logic [LIMIT_W-1:0]     retry_inc;
    logic [COPY_USED_W-1:0] cur_len_w;
    logic                   ref_avail;
    logic                   copy_avail;
    logic [HANDLE_W-1:0]    ref_handle_sel;
    logic [LENGTH_W-1:0]    ref_length_sel;
    logic [LENGTH_W-1:0]    copy_length_sel;

    always_comb begin
        len_ok    = (item.message_length != '0);
        copy_fits = (copy_used_reg + {1'b0, item.message_length})
                    <= COPY_USED_W'(COPY_BYTES);
        retry_inc = (retry_reg == RETRY_COUNT_MAX) ? retry_reg : retry_reg + 1'b1;
        cur_len_w = {1'b0, length_reg};

        res             = '0;
        ref_ctrl        = '0;
        copy_ctrl       = '0;
        finish          = 1'b0;
        try_send        = 1'b0;
        waiting_next    = waiting_reg;
        retry_next      = retry_reg;
        src_next        = src_reg;
        handle_next     = handle_reg;
        length_next     = length_reg;
        copy_start_next = copy_start_reg;
        copy_end_next   = copy_end_reg;
        copy_used_next  = copy_used_reg;

        unique case (item.operation)
            OP_ENQ_REF: begin
                if (len_ok && !ref_stat.full) begin
                    res.accepted  = 1'b1;
                    ref_ctrl.push = 1'b1;
                    try_send      = 1'b1;
                end
            end
            OP_ENQ_COPY: begin
                if (len_ok && !copy_stat.full && copy_fits) begin
                    res.accepted     = 1'b1;
                    res.write_offset = copy_end_reg;
                    copy_end_next    = copy_end_reg + item.message_length;
                    copy_used_next   = copy_used_reg + {1'b0, item.message_length};
                    copy_ctrl.push   = 1'b1;
                    try_send         = 1'b1;
                end
            end
            OP_CONFIRM: begin
                if (waiting_reg) begin
                    if (item.confirm_ok) begin
                        finish   = 1'b1;
                        try_send = 1'b1;
                    end else if (retry_inc >= limit_reg) begin
                        finish      = 1'b1;
                        res.dropped = 1'b1;
                        try_send    = 1'b1;
                    end else begin
                        retry_next            = retry_inc;
                        res.start_retry_timer = 1'b1;
                    end
                end
            end
            OP_TIMER: begin
                if (waiting_reg) begin
                    res.send_valid  = 1'b1;
                    res.send_source = src_reg;
                    res.send_handle = handle_reg;
                    res.send_length = length_reg;
                end
            end
        endcase

        if (finish) begin
            if (src_reg == SRC_COPY) begin
                copy_used_next = (copy_used_reg >= cur_len_w) ? copy_used_reg - cur_len_w : '0;
            end
            waiting_next = 1'b0;
            retry_next   = '0;
        end

        ref_avail       = ref_ctrl.push || !ref_stat.empty;
        copy_avail      = copy_ctrl.push || !copy_stat.empty;
        ref_handle_sel  = ref_stat.empty ? item.message_handle : ref_head[HANDLE_W+LENGTH_W-1:LENGTH_W];
        ref_length_sel  = ref_stat.empty ? item.message_length : ref_head[LENGTH_W-1:0];
        copy_length_sel = copy_stat.empty ? item.message_length : copy_head;

        if (try_send && (finish || !waiting_reg) && (ref_avail || copy_avail)) begin
            if (ref_avail) begin
                ref_ctrl.pop = 1'b1;
                src_next     = SRC_REF;
                handle_next  = ref_handle_sel;
                length_next  = ref_length_sel;
            end else begin
                copy_ctrl.pop   = 1'b1;
                src_next        = SRC_COPY;
                handle_next     = {{(HANDLE_W-COPY_OFF_W){1'b0}}, copy_start_reg};
                length_next     = copy_length_sel;
                copy_start_next = copy_start_reg + copy_length_sel;
            end
            waiting_next    = 1'b1;
            retry_next      = '0;
            res.send_valid  = 1'b1;
            res.send_source = src_next;
            res.send_handle = handle_next;
            res.send_length = length_next;
        end

        if (!fire) begin
            ref_ctrl  = '0;
            copy_ctrl = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_reg    <= 1'b0;
            retry_reg      <= '0;
            src_reg        <= SRC_REF;
            handle_reg     <= '0;
            length_reg     <= '0;
            copy_start_reg <= '0;
            copy_end_reg   <= '0;
            copy_used_reg  <= '0;
        end else if (fire) begin
            waiting_reg    <= waiting_next;
            retry_reg      <= retry_next;
            src_reg        <= src_next;
            handle_reg     <= handle_next;
            length_reg     <= length_next;
            copy_start_reg <= copy_start_next;
            copy_end_reg   <= copy_end_next;
            copy_used_reg  <= copy_used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= RETRY_LIMIT_RESET;
        end else if (cfg_fire) begin
            limit_reg <= cfg_data;
        end
    end

endmodule

/* rtl/core/tqrs_checker.sv */
// Port-level checks for the transmit queue retry scheduler, bound to the
// top level. Depends on tqrs_pkg and tx_queue_retry_scheduler_macros.svh.
`include "tx_queue_retry_scheduler_macros.svh"

module tqrs_checker
    import tqrs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [OP_W-1:0]       s_operation,
    input logic [HANDLE_W-1:0]   s_message_handle,
    input logic [LENGTH_W-1:0]   s_message_length,
    input logic                  s_confirm_ok,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_accepted,
    input logic [COPY_OFF_W-1:0] m_write_offset,
    input logic                  m_send_valid,
    input logic                  m_send_source,
    input logic [HANDLE_W-1:0]   m_send_handle,
    input logic [LENGTH_W-1:0]   m_send_length,
    input logic                  m_start_retry_timer,
    input logic                  m_dropped,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [LIMIT_W-1:0]    cfg_retry_limit
);

    `TQRS_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_send_handle) && $stable(m_accepted))
    `TQRS_ASSERT_NOW(a_send_nonzero_length, aclk, aresetn, m_valid && m_send_valid,
        m_send_length != '0)
    `TQRS_ASSERT_NOW(a_drop_or_retry, aclk, aresetn, m_valid && m_dropped,
        !m_start_retry_timer && !m_accepted)
    `TQRS_ASSERT_NOW(a_offset_needs_accept, aclk, aresetn, m_valid && (m_write_offset != '0),
        m_accepted)

endmodule

bind tx_queue_retry_scheduler tqrs_checker u_tqrs_checker (.*);

/* test/tx_queue_retry_scheduler_tb.sv */
// Self-checking testbench for tx_queue_retry_scheduler: directed and random
// event traffic under several retry limits, checked against a built-in model.
// Depends on tqrs_pkg and the tx_queue_retry_scheduler RTL.
module tx_queue_retry_scheduler_tb;
    import tqrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REF_SLOTS  = 64;
    localparam int COPY_SLOTS = 64;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation = OP_ENQ_REF;
    logic [HANDLE_W-1:0]   s_message_handle = '0;
    logic [LENGTH_W-1:0]   s_message_length = '0;
    logic                  s_confirm_ok = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_accepted;
    logic [COPY_OFF_W-1:0] m_write_offset;
    logic                  m_send_valid;
    logic                  m_send_source;
    logic [HANDLE_W-1:0]   m_send_handle;
    logic [LENGTH_W-1:0]   m_send_length;
    logic                  m_start_retry_timer;
    logic                  m_dropped;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LIMIT_W-1:0]    cfg_retry_limit = RETRY_LIMIT_RESET;

    tx_queue_retry_scheduler #(
        .REF_DEPTH      (REF_SLOTS),
        .COPY_MSG_DEPTH (COPY_SLOTS)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_message_handle    (s_message_handle),
        .s_message_length    (s_message_length),
        .s_confirm_ok        (s_confirm_ok),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accepted          (m_accepted),
        .m_write_offset      (m_write_offset),
        .m_send_valid        (m_send_valid),
        .m_send_source       (m_send_source),
        .m_send_handle       (m_send_handle),
        .m_send_length       (m_send_length),
        .m_start_retry_timer (m_start_retry_timer),
        .m_dropped           (m_dropped),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_retry_limit     (cfg_retry_limit)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // scheduler model state
    logic [HANDLE_W-1:0] ref_handle_q [REF_SLOTS];
    logic [LENGTH_W-1:0] ref_len_q    [REF_SLOTS];
    logic [LENGTH_W-1:0] copy_len_q   [COPY_SLOTS];
    int                  ref_rd, ref_wr, ref_cnt;
    int                  copy_rd, copy_wr, copy_cnt;
    int                  ring_start, ring_end, ring_used;
    bit                  busy;
    int                  fails;
    logic                cur_src;
    logic [HANDLE_W-1:0] cur_handle;
    logic [LENGTH_W-1:0] cur_len;
    logic [LIMIT_W-1:0]  limit_model = RETRY_LIMIT_RESET;

    item_t pending_events [$];
    res_t  expected_results [$];
    item_t held_ev;
    res_t  want;
    int    issued = 0;
    int    checked = 0;
    int    errors = 0;
    int    send_idle_pct = 15;
    int    recv_idle_pct = 52;
    int    gen_limit = RETRY_LIMIT_RESET;
    int    limit_plan [5] = '{1, 255, 0, 3, 6};

    function automatic void fill_send(inout res_t r);
        r.send_valid  = 1'b1;
        r.send_source = cur_src;
        r.send_handle = cur_handle;
        r.send_length = cur_len;
    endfunction

    function automatic void launch_next(inout res_t r);
        if (busy)
            return;
        if (ref_cnt > 0) begin
            cur_src    = SRC_REF;
            cur_handle = ref_handle_q[ref_rd];
            cur_len    = ref_len_q[ref_rd];
            ref_rd     = (ref_rd + 1) % REF_SLOTS;
            ref_cnt--;
        end else if (copy_cnt > 0) begin
            cur_src    = SRC_COPY;
            cur_handle = HANDLE_W'(ring_start);
            cur_len    = copy_len_q[copy_rd];
            ring_start = (ring_start + int'(cur_len)) % COPY_BYTES;
            copy_rd    = (copy_rd + 1) % COPY_SLOTS;
            copy_cnt--;
        end else begin
            return;
        end
        busy  = 1'b1;
        fails = 0;
        fill_send(r);
    endfunction

    function automatic void release_current();
        if (cur_src == SRC_COPY)
            ring_used = (ring_used >= int'(cur_len)) ? ring_used - int'(cur_len) : 0;
        busy  = 1'b0;
        fails = 0;
    endfunction

    function automatic res_t predict_event(item_t ev);
        res_t r;
        int   len;
        r   = '0;
        len = int'(ev.message_length);
        case (ev.operation)
            OP_ENQ_REF: begin
                if (len != 0 && ref_cnt < REF_SLOTS) begin
                    ref_handle_q[ref_wr] = ev.message_handle;
                    ref_len_q[ref_wr]    = ev.message_length;
                    ref_wr = (ref_wr + 1) % REF_SLOTS;
                    ref_cnt++;
                    r.accepted = 1'b1;
                    launch_next(r);
                end
            end
            OP_ENQ_COPY: begin
                if (len != 0 && copy_cnt < COPY_SLOTS && COPY_BYTES - ring_used >= len) begin
                    r.accepted     = 1'b1;
                    r.write_offset = COPY_OFF_W'(ring_end);
                    ring_end  = (ring_end + len) % COPY_BYTES;
                    ring_used += len;
                    copy_len_q[copy_wr] = ev.message_length;
                    copy_wr = (copy_wr + 1) % COPY_SLOTS;
                    copy_cnt++;
                    launch_next(r);
                end
            end
            OP_CONFIRM: begin
                if (busy) begin
                    if (ev.confirm_ok) begin
                        release_current();
                        launch_next(r);
                    end else begin
                        if (fails < int'(RETRY_COUNT_MAX))
                            fails++;
                        if (fails >= int'(limit_model)) begin
                            release_current();
                            r.dropped = 1'b1;
                            launch_next(r);
                        end else begin
                            r.start_retry_timer = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (busy)
                    fill_send(r);
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        errors++;
        if (errors <= 100)
            $display("ERROR result %0d: %s got %0h, expected %0h", checked, what, got, exp_val);
    endtask

    // driver: predict on acceptance, then load the next transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            limit_model <= RETRY_LIMIT_RESET;
            ref_rd = 0; ref_wr = 0; ref_cnt = 0;
            copy_rd = 0; copy_wr = 0; copy_cnt = 0;
            ring_start = 0; ring_end = 0; ring_used = 0;
            busy = 1'b0; fails = 0;
            cur_src = SRC_REF; cur_handle = '0; cur_len = '0;
        end else begin
            if (cfg_valid && cfg_ready)
                limit_model <= cfg_retry_limit;
            if (s_valid && s_ready)
                expected_results.push_back(predict_event(held_ev));
            if (!s_valid || s_ready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_ev = pending_events.pop_front();
                    issued++;
                    s_valid          <= 1'b1;
                    s_operation      <= held_ev.operation;
                    s_message_handle <= held_ev.message_handle;
                    s_message_length <= held_ev.message_length;
                    s_confirm_ok     <= held_ev.confirm_ok;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_accepted !== want.accepted)
                        report_mismatch("accepted", m_accepted, want.accepted);
                    if (m_write_offset !== want.write_offset)
                        report_mismatch("write_offset", m_write_offset, want.write_offset);
                    if (m_send_valid !== want.send_valid)
                        report_mismatch("send_valid", m_send_valid, want.send_valid);
                    if (m_send_source !== want.send_source)
                        report_mismatch("send_source", m_send_source, want.send_source);
                    if (m_send_handle !== want.send_handle)
                        report_mismatch("send_handle", m_send_handle, want.send_handle);
                    if (m_send_length !== want.send_length)
                        report_mismatch("send_length", m_send_length, want.send_length);
                    if (m_start_retry_timer !== want.start_retry_timer)
                        report_mismatch("start_retry_timer", m_start_retry_timer,
                                        want.start_retry_timer);
                    if (m_dropped !== want.dropped)
                        report_mismatch("dropped", m_dropped, want.dropped);
                    checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_event(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                               logic [LENGTH_W-1:0] len, logic ok);
        item_t ev;
        ev.operation      = op;
        ev.message_handle = handle;
        ev.message_length = len;
        ev.confirm_ok     = ok;
        pending_events.push_back(ev);
    endtask

    function automatic logic [LENGTH_W-1:0] rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return 8'd255;
        if (r < 15)
            return 8'd1;
        if (r < 60)
            return LENGTH_W'($urandom_range(1, 16));
        return LENGTH_W'($urandom_range(1, 255));
    endfunction

    task automatic gen_traffic(int budget);
        int made, kind, n, cap, lim, r;
        logic [OP_W-1:0] op;
        made = 0;
        while (made < budget) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                repeat (10) begin
                    r  = $urandom_range(99);
                    op = (r < 25) ? OP_ENQ_REF : (r < 50) ? OP_ENQ_COPY :
                         (r < 80) ? OP_CONFIRM : OP_TIMER;
                    queue_event(op, HANDLE_W'($urandom), rand_len(),
                                $urandom_range(99) < 60);
                end
                made += 10;
            end else if (kind < 46) begin
                n = $urandom_range(64, 72);
                repeat (n) queue_event(OP_ENQ_REF, HANDLE_W'($urandom), rand_len(), 1'($urandom));
                made += n;
            end else if (kind < 52) begin
                n = $urandom_range(64, 72);
                repeat (n) queue_event(OP_ENQ_COPY, HANDLE_W'($urandom),
                                       LENGTH_W'($urandom_range(1, 3)), 1'($urandom));
                made += n;
            end else if (kind < 60) begin
                n = $urandom_range(3, 6);
                repeat (n) queue_event(OP_ENQ_COPY, HANDLE_W'($urandom),
                                       LENGTH_W'($urandom_range(100, 255)), 1'($urandom));
                made += n;
            end else if (kind < 85) begin
                lim = (gen_limit == 0) ? 1 : gen_limit;
                cap = (lim > 12) ? 12 : lim + 1;
                n   = $urandom_range(1, cap);
                queue_event($urandom_range(1) ? OP_ENQ_COPY : OP_ENQ_REF,
                            HANDLE_W'($urandom), rand_len(), 1'($urandom));
                repeat (n) begin
                    queue_event(OP_CONFIRM, HANDLE_W'($urandom), LENGTH_W'($urandom), 1'b0);
                    if ($urandom_range(99) < 80)
                        queue_event(OP_TIMER, HANDLE_W'($urandom), LENGTH_W'($urandom),
                                    1'($urandom));
                end
                queue_event(OP_CONFIRM, HANDLE_W'($urandom), LENGTH_W'($urandom), 1'b1);
                made += 2 * n + 2;
            end else begin
                n = $urandom_range(1, 40);
                repeat (n) queue_event(OP_CONFIRM, HANDLE_W'($urandom), LENGTH_W'($urandom),
                                       1'b1);
                made += n;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || issued != checked)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_retry_limit(logic [LIMIT_W-1:0] value);
        cfg_retry_limit <= value;
        cfg_valid       <= 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_limit = int'(value);
    endtask

    initial begin
        int phase;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // idle confirmation and timer, zero lengths, busy enqueue, retries
        queue_event(OP_CONFIRM,  16'h1234, 8'd5,   1'b1);
        queue_event(OP_TIMER,    16'h0000, 8'd0,   1'b0);
        queue_event(OP_CONFIRM,  16'hFFFF, 8'd255, 1'b0);
        queue_event(OP_ENQ_REF,  16'hA5A5, 8'd0,   1'b0);
        queue_event(OP_ENQ_COPY, 16'h5A5A, 8'd0,   1'b1);
        queue_event(OP_ENQ_REF,  16'hFFFF, 8'd255, 1'b1);
        queue_event(OP_ENQ_COPY, 16'h0000, 8'd255, 1'b0);
        queue_event(OP_ENQ_REF,  16'h0000, 8'd1,   1'b0);
        queue_event(OP_TIMER,    16'hFFFF, 8'd255, 1'b1);
        queue_event(OP_CONFIRM,  16'h0000, 8'd0,   1'b0);
        queue_event(OP_CONFIRM,  16'h0000, 8'd0,   1'b1);
        queue_event(OP_CONFIRM,  16'h0000, 8'd0,   1'b1);
        queue_event(OP_ENQ_COPY, 16'hFFFF, 8'd1,   1'b1);
        queue_event(OP_ENQ_COPY, 16'hFFFF, 8'd1,   1'b1);
        repeat (6) queue_event(OP_CONFIRM, 16'h00FF, 8'd128, 1'b0);
        queue_event(OP_CONFIRM,  16'hFF00, 8'd0,   1'b1);
        queue_event(OP_ENQ_COPY, 16'h8001, 8'd255, 1'b0);
        queue_event(OP_CONFIRM,  16'h0000, 8'd0,   1'b1);
        gen_traffic(160);

        for (phase = 0; phase < 5; phase++) begin
            wait_idle();
            send_idle_pct <= (phase < 1) ? 15 : (phase < 3) ? 52 : 0;
            recv_idle_pct <= (phase < 1) ? 52 : (phase < 3) ? 15 : 0;
            write_retry_limit(LIMIT_W'(limit_plan[phase]));
            // run one message to the highest limit
            if (limit_plan[phase] == 255) begin
                queue_event(OP_ENQ_REF, HANDLE_W'($urandom), rand_len(), 1'b0);
                repeat (256) queue_event(OP_CONFIRM, HANDLE_W'($urandom),
                                         LENGTH_W'($urandom), 1'b0);
                queue_event(OP_CONFIRM, HANDLE_W'($urandom), LENGTH_W'($urandom), 1'b1);
            end
            gen_traffic(160);
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 0, expected_results.size());
        if (errors == 0) begin
            $display("tx_queue_retry_scheduler: match");
        end else begin
            $display("tx_queue_retry_scheduler: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tx_queue_retry_scheduler: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tqrs_pkg.sv
rtl/core/tqrs_fifo.sv
rtl/core/tqrs_sched.sv
rtl/core/tx_queue_retry_scheduler.sv
rtl/core/tqrs_checker.sv
test/tx_queue_retry_scheduler_tb.sv
